// ===== design/ussq_pkg.sv =====
// Shared types, constants and helpers for the unipolar stepper sequencer.
// No dependencies; every other design file imports this package.
package ussq_pkg;

   localparam int IntervalW = 24;
   localparam int CountInW  = 16;
   localparam int PosW      = 10;
   localparam int CoilW     = 4;
   localparam int PhaseW    = 2;

   localparam logic [IntervalW-1:0] IntervalReset = 24'd2000;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_CONTROL = 1'b1;

   typedef enum logic [1:0] {
      DIR_NONE     = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      RUN_KEEP = 2'd0,
      RUN_GO   = 2'd1,
      RUN_STOP = 2'd2
   } run_type;

   localparam logic [CoilW-1:0] COIL_OFF = 4'h0;

   typedef struct packed {
      logic                command;
      logic [1:0]          direction_code;
      logic [1:0]          run_code;
      logic [CountInW-1:0] step_count;
   } req_word_type;

   typedef struct packed {
      logic [CoilW-1:0]  coil_pattern;
      logic              running;
      logic [PosW-1:0]   position;
      logic [PhaseW-1:0] phase;
   } rsp_word_type;

   // Two-coils-on full-step sequence
   function automatic logic [CoilW-1:0] coil_lookup(input logic [PhaseW-1:0] ph);
      logic [CoilW-1:0] pat;
      case (ph)
         2'd0:    pat = 4'h6;
         2'd1:    pat = 4'h3;
         2'd2:    pat = 4'h9;
         default: pat = 4'hC;
      endcase
      return pat;
   endfunction

endpackage

// ===== design/ussq_channels.sv =====
// Valid/ready channel interfaces for the stepper sequencer: request,
// response and configuration write. Depends on ussq_pkg.
interface ussq_req_if import ussq_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface ussq_rsp_if import ussq_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface ussq_csr_if import ussq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [IntervalW-1:0] step_interval;
   modport source (output valid, output step_interval, input ready);
   modport sink (input valid, input step_interval, output ready);
endinterface

// ===== design/unipolar_stepper_sequencer_unit.sv =====
// Unipolar stepper full-step sequencer, top level.
// A result word is registered and becomes valid in the cycle after its request word is taken.
// Throughput: one word per cycle while the sink keeps up; the state update is combinational and the
// result register lets a new word in while the sink takes the last one.
// Reset: coils off, halted, phase/position/count/countdown zero, no
// direction, step interval 2000.
module unipolar_stepper_sequencer_unit import ussq_pkg::*; #(
   parameter int POSITION_MODULUS = 513,
   parameter int COUNT_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   ussq_req_if.sink    req_ch,
   ussq_rsp_if.source  rsp_ch,
   ussq_csr_if.sink    csr_ch
);

   logic [IntervalW-1:0] step_interval_ff;
   logic                 req_accept;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_in;
   rsp_word_type         rsp_word_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_interval_ff <= IntervalReset;
      end else if (csr_ch.valid) begin
         step_interval_ff <= csr_ch.step_interval;
      end
   end

   // take a word whenever the result slot frees up this cycle
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign req_accept   = req_ch.valid & req_ch.ready;

   ussq_step_core #(
      .POSITION_MODULUS (POSITION_MODULUS),
      .COUNT_BITS       (COUNT_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .req_word      (req_ch.word),
      .step_interval (step_interval_ff),
      .rsp_word_in   (rsp_word_in)
   );

   ussq_rsp_reg u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .word_in  (rsp_word_in),
      .taken    (rsp_ch.ready),
      .valid_ff (rsp_valid_ff),
      .word_ff  (rsp_word_ff)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_halted_coils_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.running) |-> rsp_word_ff.coil_pattern == COIL_OFF)
      else $error("coils driven while halted");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> {1'b0, rsp_word_ff.position} < (PosW+1)'(POSITION_MODULUS))
      else $error("position out of range");

   a_coil_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.coil_pattern == 4'h0 || rsp_word_ff.coil_pattern == 4'h6 ||
                        rsp_word_ff.coil_pattern == 4'h3 || rsp_word_ff.coil_pattern == 4'h9 ||
                        rsp_word_ff.coil_pattern == 4'hC))
      else $error("illegal coil pattern");

endmodule

// ===== design/ussq_step_core.sv =====
// Sequencer state and its next-state logic: countdown, phase, position,
// remaining steps and coil drive. Depends on ussq_pkg.
module ussq_step_core import ussq_pkg::*; #(
   parameter int POSITION_MODULUS = 513,
   parameter int COUNT_BITS       = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  req_word_type         req_word,
   input  logic [IntervalW-1:0] step_interval,
   output rsp_word_type         rsp_word_in
);

   localparam logic [PosW:0]   PosLimit = (PosW+1)'(POSITION_MODULUS);
   localparam logic [PosW-1:0] PosLast  = PosW'(POSITION_MODULUS - 1);

   logic [PhaseW-1:0]     phase_ff, phase_in;
   logic [PosW-1:0]       position_ff, position_in;
   logic [COUNT_BITS-1:0] remaining_ff, remaining_in;
   dir_type               direction_ff, direction_in;
   logic                  active_ff, active_in;
   logic [IntervalW-1:0]  countdown_ff, countdown_in;
   logic [CoilW-1:0]      coil_ff, coil_in;

   logic [COUNT_BITS-1:0] count_sat;
   logic [PosW:0]         pos_inc;

   if (COUNT_BITS >= CountInW) begin : g_wide_count
      assign count_sat = COUNT_BITS'(req_word.step_count);
   end else begin : g_narrow_count
      assign count_sat = (|req_word.step_count[CountInW-1:COUNT_BITS]) ? '1
                         : req_word.step_count[COUNT_BITS-1:0];
   end

   assign pos_inc = {1'b0, position_ff} + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      position_in  = position_ff;
      remaining_in = remaining_ff;
      direction_in = direction_ff;
      active_in    = active_ff;
      countdown_in = countdown_ff;
      coil_in      = coil_ff;
      if (accept) begin
         if (req_word.command == CMD_CONTROL) begin
            case (req_word.direction_code)
               DIR_FORWARD:  direction_in = DIR_FORWARD;
               DIR_BACKWARD: direction_in = DIR_BACKWARD;
               default:      direction_in = direction_ff;
            endcase
            case (req_word.run_code)
               RUN_GO: begin
                  active_in    = 1'b1;
                  countdown_in = step_interval;
               end
               RUN_STOP: begin
                  active_in    = 1'b0;
                  countdown_in = '0;
                  coil_in      = COIL_OFF;
               end
               default: ;
            endcase
            remaining_in = count_sat;
         end else if (active_ff) begin
            if (countdown_ff <= IntervalW'(1)) begin
               // expiry: drive current phase, then advance; the last step drops the coils instead
               coil_in = coil_lookup(phase_ff);
               if (direction_ff == DIR_FORWARD) begin
                  phase_in    = phase_ff + 1'b1;
                  position_in = (pos_inc >= PosLimit) ? '0 : pos_inc[PosW-1:0];
               end else if (direction_ff == DIR_BACKWARD) begin
                  phase_in    = phase_ff - 1'b1;
                  position_in = (position_ff == '0 || {1'b0, position_ff} >= PosLimit)
                                ? PosLast : position_ff - 1'b1;
               end
               if (remaining_ff != '0) begin
                  remaining_in = remaining_ff - 1'b1;
                  countdown_in = step_interval;
               end else begin
                  active_in    = 1'b0;
                  countdown_in = '0;
                  coil_in      = COIL_OFF;
               end
            end else begin
               countdown_in = countdown_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         position_ff  <= '0;
         remaining_ff <= '0;
         direction_ff <= DIR_NONE;
         active_ff    <= 1'b0;
         countdown_ff <= '0;
         coil_ff      <= COIL_OFF;
      end else begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         remaining_ff <= remaining_in;
         direction_ff <= direction_in;
         active_ff    <= active_in;
         countdown_ff <= countdown_in;
         coil_ff      <= coil_in;
      end
   end

   assign rsp_word_in.coil_pattern = coil_in;
   assign rsp_word_in.running      = active_in;
   assign rsp_word_in.position     = position_in;
   assign rsp_word_in.phase        = phase_in;

endmodule

// ===== design/ussq_rsp_reg.sv =====
// Result register: holds one response word until the sink takes it.
// Depends on ussq_pkg.
module ussq_rsp_reg import ussq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type word_in,
   input  logic         taken,
   output logic         valid_ff,
   output rsp_word_type word_ff
);

   logic valid_in;

   assign valid_in = load | (valid_ff & ~taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== dv/unipolar_stepper_sequencer_unit_tb.sv =====
// Self-checking testbench for unipolar_stepper_sequencer_unit: directed and random
// tick/command words, checked against an in-bench sequencer predictor.
// Depends on ussq_pkg and the ussq_*_if channel interfaces.
module unipolar_stepper_sequencer_unit_tb;
   import ussq_pkg::*;

   localparam int          CycleLimit  = 300000;
   localparam int          PositionMod = 513;
   // coil sequence, phase 0 in the low nibble
   localparam logic [15:0] CoilSeq     = 16'hC936;
   localparam logic [1:0]  DirUnknown  = 2'd3;
   localparam logic [1:0]  RunUnknown  = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ussq_req_if req_ch ();
   ussq_rsp_if rsp_ch ();
   ussq_csr_if csr_ch ();

   unipolar_stepper_sequencer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [IntervalW-1:0] m_interval  = IntervalReset;
   logic [PhaseW-1:0]    m_phase     = '0;
   logic [PosW-1:0]      m_pos       = '0;
   logic [CountInW-1:0]  m_left      = '0;
   dir_type              m_dir       = DIR_NONE;
   logic                 m_active    = 1'b0;
   logic [IntervalW-1:0] m_countdown = '0;
   logic [CoilW-1:0]     m_coils     = COIL_OFF;

   rsp_word_type pending_status[$];
   int           errors           = 0;
   int           cycle_count      = 0;
   int           src_idle_pct     = 0;
   int           snk_idle_pct     = 0;
   int           sink_hold_cycles = 0;

   function automatic rsp_word_type advance_sequencer(input req_word_type w);
      rsp_word_type r;
      if (w.command == CMD_CONTROL) begin
         if (w.direction_code == DIR_FORWARD) begin
            m_dir = DIR_FORWARD;
         end else if (w.direction_code == DIR_BACKWARD) begin
            m_dir = DIR_BACKWARD;
         end
         if (w.run_code == RUN_GO) begin
            m_active    = 1'b1;
            m_countdown = m_interval;
         end else if (w.run_code == RUN_STOP) begin
            m_active    = 1'b0;
            m_countdown = '0;
            m_coils     = COIL_OFF;
         end
         m_left = w.step_count;
      end else if (m_active) begin
         if (m_countdown <= 1) begin
            m_countdown = '0;
            m_coils     = CoilSeq[m_phase*4 +: 4];
            if (m_dir == DIR_FORWARD) begin
               m_phase = m_phase + 1'b1;
               m_pos   = (m_pos == PositionMod - 1) ? '0 : m_pos + 1'b1;
            end else if (m_dir == DIR_BACKWARD) begin
               m_phase = m_phase - 1'b1;
               m_pos   = (m_pos == 0) ? PosW'(PositionMod - 1) : m_pos - 1'b1;
            end
            if (m_left != 0) begin
               m_left      = m_left - 1'b1;
               m_countdown = m_interval;
            end else begin
               // last expiry: drop the coils at once
               m_active = 1'b0;
               m_coils  = COIL_OFF;
            end
         end else begin
            m_countdown = m_countdown - 1'b1;
         end
      end
      r.coil_pattern = m_coils;
      r.running      = m_active;
      r.position     = m_pos;
      r.phase        = m_phase;
      return r;
   endfunction

   function automatic req_word_type make_cmd(input logic [1:0] dir, input logic [1:0] run,
                                             input logic [CountInW-1:0] count);
      req_word_type w;
      w.command        = CMD_CONTROL;
      w.direction_code = dir;
      w.run_code       = run;
      w.step_count     = count;
      return w;
   endfunction

   // other fields are don't-care on a tick; randomize them
   function automatic req_word_type make_tick();
      req_word_type w;
      w.command        = CMD_TICK;
      w.direction_code = 2'($urandom_range(3));
      w.run_code       = 2'($urandom_range(3));
      w.step_count     = CountInW'($urandom_range(65535));
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      if ($urandom_range(99) < src_idle_pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.word  = w;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_status.push_back(advance_sequencer(w));
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_word(make_tick());
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_interval(input logic [IntervalW-1:0] value);
      drain_results();
      @(negedge clock);
      csr_ch.valid         = 1'b1;
      csr_ch.step_interval = value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      m_interval = value;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // result sink: random stalls plus long hold-offs on request
   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_ch.ready     = 1'b0;
            sink_hold_cycles = sink_hold_cycles - 1;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_status.size() == 0) begin
            $error("unexpected status word %h", rsp_ch.word);
            errors++;
         end else begin
            exp = pending_status.pop_front();
            if (rsp_ch.word.coil_pattern !== exp.coil_pattern) begin
               $error("coil_pattern: expected %0h, got %0h",
                      exp.coil_pattern, rsp_ch.word.coil_pattern);
               errors++;
            end
            if (rsp_ch.word.running !== exp.running) begin
               $error("running: expected %0d, got %0d", exp.running, rsp_ch.word.running);
               errors++;
            end
            if (rsp_ch.word.position !== exp.position) begin
               $error("position: expected %0d, got %0d", exp.position, rsp_ch.word.position);
               errors++;
            end
            if (rsp_ch.word.phase !== exp.phase) begin
               $error("phase: expected %0d, got %0d", exp.phase, rsp_ch.word.phase);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("unipolar_stepper_sequencer_unit test failed");
         $finish;
      end
   end

   task automatic test_halted_ticks();
      send_word('{command: CMD_TICK, direction_code: 2'b11, run_code: 2'b11,
                  step_count: 16'hFFFF});
      send_word('{command: CMD_TICK, direction_code: 2'b00, run_code: 2'b00,
                  step_count: 16'h0000});
      send_word(make_cmd(DIR_NONE, RUN_KEEP, 16'd0));
   endtask

   // expiries without a direction leave phase and position alone
   task automatic test_no_direction();
      write_interval(24'd1);
      send_word(make_cmd(DIR_NONE, RUN_GO, 16'd1));
      send_ticks(3);
   endtask

   // backward from zero wraps to the top, forward from the top wraps to zero
   task automatic test_position_wrap();
      send_word(make_cmd(DIR_BACKWARD, RUN_GO, 16'd2));
      send_ticks(1);
      send_word(make_cmd(DIR_FORWARD, RUN_KEEP, 16'd1));
      send_ticks(2);
   endtask

   task automatic test_unknown_codes();
      send_word(make_cmd(DirUnknown, RunUnknown, 16'hFFFF));
      send_word(make_cmd(DirUnknown, RUN_GO, 16'd0));
      send_ticks(1);
   endtask

   // go while running restarts the countdown; stop still loads the count
   task automatic test_restart_and_stop();
      write_interval(24'd3);
      send_word(make_cmd(DIR_FORWARD, RUN_GO, 16'd4));
      send_ticks(2);
      send_word(make_cmd(DIR_NONE, RUN_GO, 16'd4));
      send_ticks(3);
      send_word(make_cmd(DIR_BACKWARD, RUN_STOP, 16'd9));
      send_ticks(1);
   endtask

   task automatic test_interval_extremes();
      write_interval(24'd0);
      send_word(make_cmd(DIR_NONE, RUN_GO, 16'd0));
      send_ticks(1);
      write_interval(24'hFFFFFF);
      send_word(make_cmd(DIR_FORWARD, RUN_GO, 16'hFFFF));
      send_ticks(2);
      send_word(make_cmd(DIR_NONE, RUN_STOP, 16'd0));
   endtask

   // hold the sink off so the block fills and stalls its input
   task automatic test_backpressure();
      write_interval(24'd2);
      src_idle_pct     = 0;
      sink_hold_cycles = 150;
      send_word(make_cmd(DIR_FORWARD, RUN_GO, 16'd8));
      send_ticks(24);
      drain_results();
   endtask

   task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n);
      int                  sent;
      int                  burst;
      logic [CountInW-1:0] count;
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      write_interval(IntervalW'($urandom_range(1, 4)));
      sent = 0;
      while (sent < n) begin
         count = ($urandom_range(99) < 85) ? CountInW'($urandom_range(6))
                                           : CountInW'($urandom_range(65535));
         send_word(make_cmd(2'($urandom_range(3)), RUN_GO, count));
         sent++;
         burst = $urandom_range(1, m_interval * (count + 1) + 3);
         if (burst > 60) burst = 60;
         repeat (burst) begin
            // mostly ticks, with stray commands as noise
            if ($urandom_range(99) < 8) begin
               send_word(make_cmd(2'($urandom_range(3)), 2'($urandom_range(3)),
                                  CountInW'($urandom_range(65535))));
            end else begin
               send_word(make_tick());
            end
            sent++;
         end
      end
      drain_results();
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.word          = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.step_interval = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      src_idle_pct = 18;
      snk_idle_pct = 58;
      test_halted_ticks();
      test_no_direction();
      test_position_wrap();
      test_unknown_codes();
      test_restart_and_stop();
      test_interval_extremes();
      test_backpressure();
      test_random_traffic(18, 58, 500);
      test_random_traffic(58, 18, 500);
      test_random_traffic(0, 0, 500);

      drain_results();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("unipolar_stepper_sequencer_unit test passed");
      end else begin
         $display("unipolar_stepper_sequencer_unit test failed");
      end
      $finish;
   end

endmodule
